[rtl/core/rhc_pkg.sv]
package rhc_pkg;

	// Field widths
	localparam int CH_W     = 8;
	localparam int HUE_W    = 15;
	localparam int SAT_W    = 16;

	// Hue scale: 60 degrees in units of 1/64 degree
	localparam int HUE_FRAC = 6;
	localparam int HUE_UNIT = 60 << HUE_FRAC;
	localparam int SAT_FRAC = 15;

	// Divider shape: quotient bits and steps per pipeline stage
	localparam int HUE_Q_W         = 12;
	localparam int SAT_Q_W         = 16;
	localparam int Q_W             = SAT_Q_W;
	localparam int HNUM_W          = CH_W + HUE_Q_W;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = (SAT_Q_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	// Stage numbering: front end, divider stages, output register
	localparam int FRONT    = 1;
	localparam int DIV_LAST = FRONT + DIV_STAGES;
	localparam int OUT_STG  = DIV_LAST + 1;

	// Sextant base offsets, picked by the smallest channel
	localparam logic [HUE_W-1:0] HUE_BASE_RED_LOW   = HUE_W'(3 * HUE_UNIT);
	localparam logic [HUE_W-1:0] HUE_BASE_GREEN_LOW = HUE_W'(5 * HUE_UNIT);
	localparam logic [HUE_W-1:0] HUE_BASE_BLUE_LOW  = HUE_W'(1 * HUE_UNIT);

	localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(6 * HUE_UNIT);
	localparam logic [SAT_W-1:0] SAT_MAX = SAT_W'(1 << SAT_FRAC);

	// Partial remainder and dividend/quotient shift register
	typedef struct packed {
		logic [CH_W-1:0] rem;
		logic [Q_W-1:0]  quo;
	} div_step_t;

	// One restoring division step
	function automatic div_step_t div_step(input div_step_t cur, input logic [CH_W-1:0] dv);
		logic [CH_W:0] trial;
		div_step_t     nxt;
		trial = {cur.rem, cur.quo[Q_W-1]};
		if (trial >= {1'b0, dv}) begin
			nxt.rem = CH_W'(trial - {1'b0, dv});
			nxt.quo = {cur.quo[Q_W-2:0], 1'b1};
		end else begin
			nxt.rem = trial[CH_W-1:0];
			nxt.quo = {cur.quo[Q_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

[rtl/core/rgb_to_hsv_convert_top.sv]
// Channel   Handshake                Payload
// input     in_valid / in_ready      red, green, blue
// output    out_valid / out_ready    hue, saturation, value_level, hue_defined
//
// One pixel per clock unless the output stalls. From input transaction to output valid:
// one front-end stage (max/min, sextant, hue numerator), eight divider stages
// retiring two saturation and, up to 12 bits, two hue quotient bits each; one output stage.
// arst_n clears all stage valid bits; the datapath registers are not reset.
// Each stage holds its data when the stage after it is full and stalled, so an
// empty stage still takes a transaction while the output waits to be taken.
module rgb_to_hsv_convert_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rhc_pkg::CH_W-1:0]          red,
	input  logic [rhc_pkg::CH_W-1:0]          green,
	input  logic [rhc_pkg::CH_W-1:0]          blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rhc_pkg::HUE_W-1:0]         hue,
	output logic [rhc_pkg::SAT_W-1:0]         saturation,
	output logic [rhc_pkg::CH_W-1:0]          value_level,
	output logic                              hue_defined
);
	import rhc_pkg::*;

	// Stage valid bits and per-stage load enables
	logic [FRONT:OUT_STG]   vld_s;
	logic [FRONT:OUT_STG+1] take;

	// Front end and divider stage data
	div_step_t         h_div_s [FRONT:DIV_LAST];
	div_step_t         s_div_s [FRONT:DIV_LAST];
	logic [CH_W-1:0]   dv_s    [FRONT:DIV_LAST];
	logic [CH_W-1:0]   hi_s    [FRONT:DIV_LAST];
	logic [HUE_W-1:0]  hb_s    [FRONT:DIV_LAST];
	logic              sub_s   [FRONT:DIV_LAST];
	logic              gray_s  [FRONT:DIV_LAST];

	// Output stage
	logic [HUE_W-1:0]  hue_out_q;
	logic [SAT_W-1:0]  sat_out_q;
	logic [CH_W-1:0]   val_out_q;
	logic              def_out_q;

	// Front-end combinational results
	logic [CH_W-1:0]   hi, lo, d, pos, neg, m;
	logic [HUE_W-1:0]  base;
	logic              sub;
	logic [HNUM_W-1:0] hnum;

	// Stall chain: a stage loads when it is empty or its content moves on
	always_comb begin
		take[OUT_STG+1] = out_ready;
		for (int k = OUT_STG; k >= FRONT; k--) begin
			take[k] = !vld_s[k] || take[k+1];
		end
	end

	assign in_ready = take[FRONT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (take[FRONT]) begin
				vld_s[FRONT] <= in_valid;
			end
			for (int k = FRONT + 1; k <= OUT_STG; k++) begin
				if (take[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Max, min, sextant base and signed channel difference
	always_comb begin
		hi = (red > green) ? red : green;
		if (blue > hi) begin
			hi = blue;
		end
		lo = (red < green) ? red : green;
		if (blue < lo) begin
			lo = blue;
		end
		d = hi - lo;

		if (red == lo) begin
			base = HUE_BASE_RED_LOW;
			pos  = green;
			neg  = blue;
		end else if (green == lo) begin
			base = HUE_BASE_GREEN_LOW;
			pos  = blue;
			neg  = red;
		end else begin
			base = HUE_BASE_BLUE_LOW;
			pos  = red;
			neg  = green;
		end

		sub  = (pos >= neg);
		m    = sub ? (pos - neg) : (neg - pos);
		hnum = HNUM_W'(m * HUE_UNIT);
	end

	// Stage 1: load divider start values
	always_ff @(posedge clk) begin
		if (take[FRONT]) begin
			h_div_s[FRONT] <= '{rem: hnum[HNUM_W-1:HUE_Q_W],
				quo: {hnum[HUE_Q_W-1:0], (Q_W-HUE_Q_W)'(0)}};
			s_div_s[FRONT] <= '{rem: d >> 1, quo: {d[0], (Q_W-1)'(0)}};
			dv_s[FRONT]    <= d;
			hi_s[FRONT]    <= hi;
			hb_s[FRONT]    <= base;
			sub_s[FRONT]   <= sub;
			gray_s[FRONT]  <= (d == '0);
		end
	end

	// Divider stages: two restoring steps each, hue stops after its 12 bits
	for (genvar k = FRONT + 1; k <= DIV_LAST; k++) begin : g_div
		div_step_t h_nxt, s_nxt;

		always_comb begin
			h_nxt = h_div_s[k-1];
			s_nxt = s_div_s[k-1];
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				if ((k - FRONT - 1) * STEPS_PER_STAGE + j < HUE_Q_W) begin
					h_nxt = div_step(h_nxt, dv_s[k-1]);
				end
				if ((k - FRONT - 1) * STEPS_PER_STAGE + j < SAT_Q_W) begin
					s_nxt = div_step(s_nxt, hi_s[k-1]);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (take[k]) begin
				h_div_s[k] <= h_nxt;
				s_div_s[k] <= s_nxt;
				dv_s[k]    <= dv_s[k-1];
				hi_s[k]    <= hi_s[k-1];
				hb_s[k]    <= hb_s[k-1];
				sub_s[k]   <= sub_s[k-1];
				gray_s[k]  <= gray_s[k-1];
			end
		end
	end

	// Output stage: apply hue offset, zero the fields for gray
	logic [HUE_W-1:0] hue_quo;
	logic [HUE_W-1:0] hue_calc;

	always_comb begin
		hue_quo  = HUE_W'(h_div_s[DIV_LAST].quo[HUE_Q_W-1:0]);
		hue_calc = sub_s[DIV_LAST] ? (hb_s[DIV_LAST] - hue_quo) : (hb_s[DIV_LAST] + hue_quo);
	end

	always_ff @(posedge clk) begin
		if (take[OUT_STG]) begin
			hue_out_q <= gray_s[DIV_LAST] ? '0 : hue_calc;
			sat_out_q <= gray_s[DIV_LAST] ? '0 : s_div_s[DIV_LAST].quo[SAT_Q_W-1:0];
			val_out_q <= hi_s[DIV_LAST];
			def_out_q <= !gray_s[DIV_LAST];
		end
	end

	assign out_valid   = vld_s[OUT_STG];
	assign hue         = hue_out_q;
	assign saturation  = sat_out_q;
	assign value_level = val_out_q;
	assign hue_defined = def_out_q;

	// Gray pixels give zero hue and saturation
	a_gray_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hue_defined |-> hue == '0 && saturation == '0)
		else $error("gray pixel with nonzero hue or saturation");

	// A colored pixel always has some saturation, never above full scale
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hue_defined |-> saturation != '0 && saturation <= SAT_MAX)
		else $error("saturation out of range");

	// Hue stays within one turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue <= HUE_MAX)
		else $error("hue beyond 360 degrees");

	// A transaction taken with a free pipeline leaves stage 1 occupied
	a_front_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[FRONT])
		else $error("accepted transaction lost at stage 1");

endmodule

[bench/rgb_to_hsv_convert_top_test.sv]
`timescale 1ns / 1ps

module rgb_to_hsv_convert_top_test;

	import rhc_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 3;
	localparam int LONG_HOLD      = 200;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int CH_MAX         = (1 << CH_W) - 1;

	// One converted pixel, as seen on the output port
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [CH_W-1:0]  value_level;
		logic             hue_defined;
	} hsv_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic             out_valid;
	logic             out_ready;
	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;
	logic [CH_W-1:0]  value_level;
	logic             hue_defined;

	hsv_t pending_hsv[$];
	int   mismatches;
	int   pixels_checked;
	bit   tx_gaps;
	bit   rx_stalls;
	bit   long_hold;

	rgb_to_hsv_convert_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hue         (hue),
		.saturation  (saturation),
		.value_level (value_level),
		.hue_defined (hue_defined)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Expected HSV for one pixel
	function automatic hsv_t predict_hsv(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
		hsv_t res;
		int   hi, lo, spread, base, pos, neg, q, h;
		hi = (r > g) ? r : g;
		if (b > hi) hi = b;
		lo = (r < g) ? r : g;
		if (b < lo) lo = b;
		spread = hi - lo;
		res.value_level = CH_W'(hi);
		if (spread == 0) begin
			res.hue         = '0;
			res.saturation  = '0;
			res.hue_defined = 1'b0;
			return res;
		end
		// sextant from the smallest channel; red wins ties, then green
		if (r == lo) begin
			base = HUE_BASE_RED_LOW;   pos = g; neg = b;
		end else if (g == lo) begin
			base = HUE_BASE_GREEN_LOW; pos = b; neg = r;
		end else begin
			base = HUE_BASE_BLUE_LOW;  pos = r; neg = g;
		end
		// quotient on the magnitude, sign applied afterwards
		if (pos >= neg) begin
			q = (HUE_UNIT * (pos - neg)) / spread;
			h = base - q;
		end else begin
			q = (HUE_UNIT * (neg - pos)) / spread;
			h = base + q;
		end
		res.hue         = HUE_W'(h);
		res.saturation  = SAT_W'((spread << SAT_FRAC) / hi);
		res.hue_defined = 1'b1;
		return res;
	endfunction

	function automatic void report_field(string name, int expected, int actual);
		if (expected != actual) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
				actual);
			mismatches++;
		end
	endfunction

	// Record expectations on input transactions, check output transactions
	always @(posedge clk) begin
		hsv_t want;
		if (in_valid && in_ready)
			pending_hsv.push_back(predict_hsv(red, green, blue));
		if (out_valid && out_ready) begin
			if (pending_hsv.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual hue %0d sat %0d val %0d",
					$time, hue, saturation, value_level);
				mismatches++;
			end else begin
				want = pending_hsv.pop_front();
				report_field("hue", want.hue, hue);
				report_field("saturation", want.saturation, saturation);
				report_field("value_level", want.value_level, value_level);
				report_field("hue_defined", want.hue_defined, hue_defined);
			end
			pixels_checked++;
		end
	end

	// Output side: random stall bursts, plus the long hold on request
	initial begin : receiver
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold = 1'b0;
			end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Ends the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Offer one pixel, optionally after an idle burst, and wait for the transaction
	task automatic send_pixel(input int r, input int g, input int b);
		int gap;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		red      <= CH_W'(r);
		green    <= CH_W'(g);
		blue     <= CH_W'(b);
		do @(posedge clk); while (!in_ready);
	endtask

	// Mix of fully random, near-gray and saturated colors
	task automatic send_random_pixel();
		int mode, level, r, g, b;
		mode = $urandom_range(0, 3);
		if (mode == 0) begin
			// spread of at most a few codes, often zero
			level = $urandom_range(0, CH_MAX);
			r = level + $urandom_range(0, 2);
			g = level + $urandom_range(0, 2);
			b = level + $urandom_range(0, 2);
			if (r > CH_MAX) r = CH_MAX;
			if (g > CH_MAX) g = CH_MAX;
			if (b > CH_MAX) b = CH_MAX;
		end else if (mode == 1) begin
			// channels at the rails or anywhere
			r = ($urandom_range(0, 2) == 0) ? $urandom_range(0, CH_MAX) : CH_MAX * $urandom_range(0, 1);
			g = ($urandom_range(0, 2) == 0) ? $urandom_range(0, CH_MAX) : CH_MAX * $urandom_range(0, 1);
			b = ($urandom_range(0, 2) == 0) ? $urandom_range(0, CH_MAX) : CH_MAX * $urandom_range(0, 1);
		end else begin
			r = $urandom_range(0, CH_MAX);
			g = $urandom_range(0, CH_MAX);
			b = $urandom_range(0, CH_MAX);
		end
		send_pixel(r, g, b);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_hsv.size() != 0) @(posedge clk);
	endtask

	// Gray, primaries, secondaries, minimum ties, both hue signs, tiny spreads
	task automatic test_corner_colors();
		send_pixel(0, 0, 0);
		send_pixel(CH_MAX, CH_MAX, CH_MAX);
		send_pixel(128, 128, 128);
		send_pixel(CH_MAX, 0, 0);
		send_pixel(0, CH_MAX, 0);
		send_pixel(0, 0, CH_MAX);
		send_pixel(CH_MAX, CH_MAX, 0);
		send_pixel(0, CH_MAX, CH_MAX);
		send_pixel(CH_MAX, 0, CH_MAX);
		send_pixel(10, 10, 200);
		send_pixel(200, 10, 10);
		send_pixel(10, 200, 10);
		send_pixel(1, 0, 0);
		send_pixel(CH_MAX, CH_MAX - 1, CH_MAX);
		send_pixel(0, 1, 0);
		send_pixel(0, 0, 1);
		send_pixel(CH_MAX, 0, 100);
		send_pixel(100, 0, CH_MAX);
		send_pixel(0, 100, CH_MAX);
		send_pixel(0, CH_MAX, 100);
		send_pixel(CH_MAX, 100, 0);
		send_pixel(100, CH_MAX, 0);
		send_pixel(170, 85, 42);
		wait_idle();
	endtask

	// Random pixels with idle bursts on both sides
	task automatic test_random_with_stalls(input int count);
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		repeat (count) send_random_pixel();
		wait_idle();
	endtask

	// Output held off while pixels keep coming, so the pipeline fills and stalls
	task automatic test_output_hold(input int count);
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		long_hold = 1'b1;
		repeat (count) send_random_pixel();
		while (long_hold) @(posedge clk);
		wait_idle();
	endtask

	// Back-to-back pixels with both sides always ready
	task automatic test_full_rate(input int count);
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		repeat (count) send_random_pixel();
		wait_idle();
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		red            = '0;
		green          = '0;
		blue           = '0;
		mismatches     = 0;
		pixels_checked = 0;
		tx_gaps        = 1'b0;
		rx_stalls      = 1'b0;
		long_hold      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_colors();
		test_random_with_stalls(400);
		test_output_hold(40);
		test_full_rate(400);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_hsv.size() != 0) begin
			$display("%0t: %0d pixels never produced a result", $time, pending_hsv.size());
			mismatches++;
		end
		$display("Converted %0d pixels: gray, primaries, minimum ties and random colors,",
			pixels_checked);
		$display("with random stalls, a %0d-cycle output hold and a full-rate stream; %0d errors",
			LONG_HOLD, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
